### hdl/rkc_pkg.sv
`timescale 1ns / 1ps
// rkc_pkg: shared types, field widths and helpers for the RGB kernel convolution unit.
// No dependencies.
package rkc_pkg;

    localparam int COORD_W    = 14;
    localparam int KSIDE_W    = 4;
    localparam int IN_W       = 64;
    localparam int OUT_W      = 40;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int PROD_W     = 25;
    localparam int ACC_W      = 34;

    typedef enum logic [1:0] {
        MODE_COEF    = 2'd0,
        MODE_PIXEL   = 2'd1,
        MODE_COMPUTE = 2'd2,
        MODE_NOP     = 2'd3
    } t_mode;

    localparam logic [CFG_IDX_W-1:0] CFG_IMG_W = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMG_H = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KER_W = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KER_H = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_RUN   = 3'b010,
        S_DRAIN = 3'b100
    } t_state;

    typedef struct packed {
        logic write;
        logic start;
        logic issue;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic last_tap;
        logic pipe_busy;
        logic out_free;
    } t_status;

    // Signed Q26.8 sum to byte: truncate toward zero, saturate to 0..255
    function automatic logic [7:0] to_byte(input logic signed [ACC_W-1:0] acc);
        logic [7:0] res;
        if (acc[ACC_W-1] || (acc == '0)) begin
            res = 8'd0;
        end else if (|acc[ACC_W-1:16]) begin
            res = 8'd255;
        end else begin
            res = acc[15:8];
        end
        return res;
    endfunction

endpackage

### hdl/rkc_ctrl.sv
`timescale 1ns / 1ps
// rkc_ctrl: sequencer for the convolution unit; issues commands to rkc_datapath.
// Depends on rkc_pkg.
module rkc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_in_mode,
    output logic              o_in_ready,
    input  rkc_pkg::t_status  i_status,
    output rkc_pkg::t_cmd     o_cmd
);
    import rkc_pkg::*;

    t_state r_state, n_state;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state        = r_state;
        o_cmd.write    = 1'b0;
        o_cmd.start    = 1'b0;
        o_cmd.issue    = 1'b0;
        o_cmd.load_out = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_cmd.write = accept;
                if (accept && (i_in_mode == MODE_COMPUTE)) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_RUN;
                end
            end
            S_RUN: begin
                o_cmd.issue = 1'b1;
                if (i_status.last_tap) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_status.pipe_busy && i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### hdl/rkc_datapath.sv
`timescale 1ns / 1ps
// rkc_datapath: config registers, pixel and weight stores, tap walk, MAC pipeline
// and output register. Depends on rkc_pkg.
module rkc_datapath #(
    parameter int MAX_WIDTH       = 256,
    parameter int MAX_HEIGHT      = 256,
    parameter int MAX_KERNEL_SIDE = 7
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rkc_pkg::t_cmd                   i_cmd,
    output rkc_pkg::t_status                o_status,
    input  logic [rkc_pkg::IN_W-1:0]        i_in_data,
    input  logic                            i_cfg_wr_en,
    input  logic [rkc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rkc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [rkc_pkg::OUT_W-1:0]       o_out_data
);
    import rkc_pkg::*;

    localparam int XW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW        = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int PIX_DEPTH = 2 ** (XW + YW);
    localparam int W_DEPTH   = MAX_KERNEL_SIDE * MAX_KERNEL_SIDE;
    localparam int WAW       = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;

    // input fields
    logic [1:0]         in_mode;
    logic [7:0]         in_row, in_col, in_red, in_green, in_blue;
    logic [15:0]        in_coef;
    assign in_mode  = i_in_data[1:0];
    assign in_row   = i_in_data[9:2];
    assign in_col   = i_in_data[17:10];
    assign in_red   = i_in_data[25:18];
    assign in_green = i_in_data[33:26];
    assign in_blue  = i_in_data[41:34];
    assign in_coef  = i_in_data[57:42];

    // config
    logic [8:0] r_img_w, r_img_h;
    logic [2:0] r_ker_w, r_ker_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= 9'd256;
            r_img_h <= 9'd256;
            r_ker_w <= 3'd3;
            r_ker_h <= 3'd3;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_IMG_W: r_img_w <= i_cfg_data;
                CFG_IMG_H: r_img_h <= i_cfg_data;
                CFG_KER_W: r_ker_w <= i_cfg_data[2:0];
                CFG_KER_H: r_ker_h <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    logic [COORD_W-1:0] img_w_sat, img_h_sat;
    logic [KSIDE_W-1:0] ker_w_sat, ker_h_sat;

    always_comb begin
        if (r_img_w == '0) begin
            img_w_sat = COORD_W'(1);
        end else if (COORD_W'(r_img_w) > COORD_W'(MAX_WIDTH)) begin
            img_w_sat = COORD_W'(MAX_WIDTH);
        end else begin
            img_w_sat = COORD_W'(r_img_w);
        end
        if (r_img_h == '0) begin
            img_h_sat = COORD_W'(1);
        end else if (COORD_W'(r_img_h) > COORD_W'(MAX_HEIGHT)) begin
            img_h_sat = COORD_W'(MAX_HEIGHT);
        end else begin
            img_h_sat = COORD_W'(r_img_h);
        end
        if (r_ker_w == '0) begin
            ker_w_sat = KSIDE_W'(1);
        end else if (KSIDE_W'(r_ker_w) > KSIDE_W'(MAX_KERNEL_SIDE)) begin
            ker_w_sat = KSIDE_W'(MAX_KERNEL_SIDE);
        end else begin
            ker_w_sat = KSIDE_W'(r_ker_w);
        end
        if (r_ker_h == '0) begin
            ker_h_sat = KSIDE_W'(1);
        end else if (KSIDE_W'(r_ker_h) > KSIDE_W'(MAX_KERNEL_SIDE)) begin
            ker_h_sat = KSIDE_W'(MAX_KERNEL_SIDE);
        end else begin
            ker_h_sat = KSIDE_W'(r_ker_h);
        end
    end

    // store writes
    logic [COORD_W-1:0] row_ext, col_ext;
    logic               pix_wr, coef_wr;
    logic [XW+YW-1:0]   pix_waddr;
    logic [7:0]         coef_waddr_full;
    assign row_ext         = COORD_W'(in_row);
    assign col_ext         = COORD_W'(in_col);
    assign pix_wr          = i_cmd.write && (in_mode == MODE_PIXEL)
                             && (row_ext < COORD_W'(MAX_HEIGHT))
                             && (col_ext < COORD_W'(MAX_WIDTH));
    assign coef_wr         = i_cmd.write && (in_mode == MODE_COEF)
                             && (row_ext < COORD_W'(MAX_KERNEL_SIDE))
                             && (col_ext < COORD_W'(MAX_KERNEL_SIDE));
    assign pix_waddr       = {row_ext[YW-1:0], col_ext[XW-1:0]};
    assign coef_waddr_full = 8'(in_row[3:0]) * 8'(MAX_KERNEL_SIDE) + 8'(in_col[3:0]);

    // tap walk
    logic [7:0]         r_row, r_col;
    logic [KSIDE_W-1:0] r_u, r_v;
    logic               last_u, last_v;
    assign last_u = (r_u == ker_w_sat - KSIDE_W'(1));
    assign last_v = (r_v == ker_h_sat - KSIDE_W'(1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_row <= in_row;
            r_col <= in_col;
            r_u   <= '0;
            r_v   <= '0;
        end else if (i_cmd.issue) begin
            if (last_u) begin
                r_u <= '0;
                r_v <= r_v + KSIDE_W'(1);
            end else begin
                r_u <= r_u + KSIDE_W'(1);
            end
        end
    end

    logic [COORD_W-1:0] y_raw, x_raw, y_cl, x_cl;
    logic [XW+YW-1:0]   pix_raddr;
    logic [7:0]         coef_raddr_full;
    assign y_raw = COORD_W'(r_row) + COORD_W'(r_v) - COORD_W'(ker_h_sat >> 1);
    assign x_raw = COORD_W'(r_col) + COORD_W'(r_u) - COORD_W'(ker_w_sat >> 1);

    // negative wraps set the top bit; clamp both ends
    always_comb begin
        if (y_raw[COORD_W-1]) begin
            y_cl = '0;
        end else if (y_raw >= img_h_sat) begin
            y_cl = img_h_sat - COORD_W'(1);
        end else begin
            y_cl = y_raw;
        end
        if (x_raw[COORD_W-1]) begin
            x_cl = '0;
        end else if (x_raw >= img_w_sat) begin
            x_cl = img_w_sat - COORD_W'(1);
        end else begin
            x_cl = x_raw;
        end
    end

    assign pix_raddr       = {y_cl[YW-1:0], x_cl[XW-1:0]};
    assign coef_raddr_full = 8'(r_v) * 8'(MAX_KERNEL_SIDE) + 8'(r_u);

    // stores
    logic [23:0] r_pix_mem [0:PIX_DEPTH-1];
    logic [15:0] r_coef_mem [0:W_DEPTH-1];
    logic [23:0] r_pix_rd;
    logic [15:0] r_coef_rd;

    always_ff @(posedge i_clk) begin
        if (pix_wr) begin
            r_pix_mem[pix_waddr] <= {in_red, in_green, in_blue};
        end
        r_pix_rd <= r_pix_mem[pix_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (coef_wr) begin
            r_coef_mem[coef_waddr_full[WAW-1:0]] <= in_coef;
        end
        r_coef_rd <= r_coef_mem[coef_raddr_full[WAW-1:0]];
    end

    // MAC pipeline
    logic                      r_rd_vld, r_prod_vld;
    logic signed [PROD_W-1:0]  r_prod_r, r_prod_g, r_prod_b;
    logic signed [ACC_W-1:0]   r_acc_r, r_acc_g, r_acc_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld   <= 1'b0;
            r_prod_vld <= 1'b0;
        end else begin
            r_rd_vld   <= i_cmd.issue;
            r_prod_vld <= r_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod_r <= $signed(r_coef_rd) * $signed({1'b0, r_pix_rd[23:16]});
        r_prod_g <= $signed(r_coef_rd) * $signed({1'b0, r_pix_rd[15:8]});
        r_prod_b <= $signed(r_coef_rd) * $signed({1'b0, r_pix_rd[7:0]});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_acc_r <= '0;
            r_acc_g <= '0;
            r_acc_b <= '0;
        end else if (r_prod_vld) begin
            r_acc_r <= r_acc_r + {{(ACC_W-PROD_W){r_prod_r[PROD_W-1]}}, r_prod_r};
            r_acc_g <= r_acc_g + {{(ACC_W-PROD_W){r_prod_g[PROD_W-1]}}, r_prod_g};
            r_acc_b <= r_acc_b + {{(ACC_W-PROD_W){r_prod_b[PROD_W-1]}}, r_prod_b};
        end
    end

    // output register
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data <= {to_byte(r_acc_b), to_byte(r_acc_g), to_byte(r_acc_r),
                           r_col, r_row};
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_out_data         = r_out_data;
    assign o_status.last_tap  = last_u && last_v;
    assign o_status.pipe_busy = r_rd_vld || r_prod_vld;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

endmodule

### hdl/rgb_kernel_convolution_unit.sv
`timescale 1ns / 1ps
// rgb_kernel_convolution_unit: top level; joins rkc_ctrl and rkc_datapath.
// Depends on rkc_pkg, rkc_ctrl, rkc_datapath.
//
// Usage:
//   The slave stream carries commands: mode 0 writes a Q8.8 kernel weight at
//   (row, col), mode 1 writes an RGB pixel at (row, col), mode 2 requests the
//   filtered pixel at (row, col), mode 3 is dropped. Only mode 2 produces a
//   transaction on the master stream: row, col and the three filtered bytes.
//   The config port (i_cfg_wr_en/index/data) sets image and kernel size; write
//   it only while no compute is in flight.
//   Write commands are accepted one per cycle while idle. A compute walks the
//   kernel window one tap per cycle through a registered store read, a
//   registered multiply and an accumulate per channel: s_axis_tready stays
//   low from acceptance until the result is loaded, and the result shows on
//   the master side as ready returns.
//   The output register holds one result; further writes are accepted while
//   it waits. If the receiver stalls, a following compute finishes and then
//   holds off until the pending result is taken.
//   Reset (synchronous, active low) clears the controller, the output valid
//   and restores size registers to 256x256 image, 3x3 kernel. Store contents
//   are undefined until written.
module rgb_kernel_convolution_unit #(
    parameter int MAX_WIDTH       = 256,
    parameter int MAX_HEIGHT      = 256,
    parameter int MAX_KERNEL_SIDE = 7
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // mode[1:0], row[9:2], col[17:10], red_in[25:18], green_in[33:26],
    // blue_in[41:34], coefficient[57:42], zero pad[63:58]
    input  logic [rkc_pkg::IN_W-1:0]        s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // out_row[7:0], out_col[15:8], red_out[23:16], green_out[31:24],
    // blue_out[39:32]
    output logic [rkc_pkg::OUT_W-1:0]       m_axis_tdata,
    input  logic                            i_cfg_wr_en,
    input  logic [rkc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rkc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import rkc_pkg::*;

    t_cmd    cmd;
    t_status status;

    rkc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_mode  (s_axis_tdata[1:0]),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    rkc_datapath #(
        .MAX_WIDTH       (MAX_WIDTH),
        .MAX_HEIGHT      (MAX_HEIGHT),
        .MAX_KERNEL_SIDE (MAX_KERNEL_SIDE)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_data   (s_axis_tdata),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule

### hdl/rkc_checker.sv
`timescale 1ns / 1ps
// rkc_checker: port-level assertions for rgb_kernel_convolution_unit, bound below.
// Depends on rkc_pkg.
module rkc_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       s_axis_tvalid,
    input logic                       s_axis_tready,
    input logic [rkc_pkg::IN_W-1:0]   s_axis_tdata,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [rkc_pkg::OUT_W-1:0]  m_axis_tdata
);
    import rkc_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tdata[1:0] == MODE_COMPUTE)
        |=> !s_axis_tready)
        else $error("ready stayed high after compute transaction");

    a_write_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tdata[1:0] != MODE_COMPUTE)
        |=> s_axis_tready)
        else $error("write transaction stalled the input");

    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without compute in flight");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind rgb_kernel_convolution_unit rkc_checker u_rkc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
